// File: rtl/core/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared clocked assertion forms for the alarm controller RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold in the same cycle, checked outside reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/aic_pkg.sv
// ============================================================================
// aic_pkg
// Types, codes and fixed constants of the intrusion alarm controller.
// ============================================================================
`timescale 1ns / 1ps

package aic_pkg;

    // Fixed build constants of the controller.
    localparam int NUM_SENSORS = 6;
    localparam int PIN_DIGITS  = 4;

    // Only the low six sensor bits exist on the word; the rest are masked.
    localparam int SENS_USED = (NUM_SENSORS > 6) ? 6 : NUM_SENSORS;
    localparam logic [5:0] SENSOR_MASK = 6'((12'd1 << SENS_USED) - 12'd1);

    // Eight bits per PIN character, at most four characters compared.
    localparam logic [31:0] PIN_MASK = (PIN_DIGITS >= 4) ? 32'hFFFF_FFFF :
                                       32'((64'd1 << (8 * PIN_DIGITS)) - 64'd1);

    // Modes.
    localparam logic [1:0] MODE_DAY   = 2'd0;
    localparam logic [1:0] MODE_NIGHT = 2'd1;
    localparam logic [1:0] MODE_IDLE  = 2'd2;
    localparam logic [1:0] MODE_OTHER = 2'd3;

    // Command kinds.
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_MODE  = 3'd1;
    localparam logic [2:0] KIND_FACE  = 3'd2;
    localparam logic [2:0] KIND_PIN   = 3'd3;
    localparam logic [2:0] KIND_LEVEL = 3'd4;

    // PIN verdicts.
    localparam logic [1:0] VERDICT_NONE  = 2'd0;
    localparam logic [1:0] VERDICT_OK    = 2'd1;
    localparam logic [1:0] VERDICT_WRONG = 2'd2;
    localparam logic [1:0] VERDICT_ALARM = 2'd3;

    // Access levels set by commands.
    localparam logic [3:0] LEVEL_NONE = 4'd0;
    localparam logic [3:0] LEVEL_PIN  = 4'd1;
    localparam logic [3:0] LEVEL_FACE = 4'd2;

    // Wrong PIN handling.
    localparam logic [7:0] WRONG_LIMIT = 8'd3;
    localparam logic [7:0] WRONG_MAX   = 8'd255;

    // Configuration register map.
    localparam int CFG_ADDR_W = 5;
    localparam logic [2:0] REG_ENTRY_DELAY = 3'd0;
    localparam logic [2:0] REG_BUZZER_LIM  = 3'd1;
    localparam logic [2:0] REG_REPORT_INT  = 3'd2;
    localparam logic [2:0] REG_CORRECT_PIN = 3'd3;
    localparam logic [2:0] REG_START_MODE  = 3'd4;

    // Register reset values.
    localparam logic [31:0] RST_ENTRY_DELAY = 32'd5000;
    localparam logic [31:0] RST_BUZZER_LIM  = 32'd4000;
    localparam logic [15:0] RST_REPORT_INT  = 16'd80;
    localparam logic [31:0] RST_CORRECT_PIN = 32'h3132_3334;
    localparam logic [1:0]  RST_START_MODE  = MODE_DAY;

    // Configuration seen by the control pass.
    typedef struct packed {
        logic [31:0] entry_delay_ms;
        logic [31:0] buzzer_limit_ms;
        logic [15:0] report_interval_ms;
        logic [31:0] correct_pin;
    } t_cfg;

    // One input word.
    typedef struct packed {
        logic        tick;
        logic [5:0]  day_sensors;
        logic [5:0]  night_sensors;
        logic [2:0]  kind;
        logic [1:0]  mode_value;
        logic [31:0] pin_code;
        logic [3:0]  access_digit;
    } t_item;

    // One result word.
    typedef struct packed {
        logic       lamps_on;
        logic       buzzer_on;
        logic       door_locked;
        logic       alarm_state;
        logic [3:0] level_now;
        logic [1:0] mode_now;
        logic [1:0] pin_verdict;
        logic       report_due;
        logic [5:0] day_tripped;
        logic [5:0] night_tripped;
    } t_result;

endpackage

// File: rtl/core/intrusion_alarm_controller_top.sv
// ============================================================================
// intrusion_alarm_controller_top
// Intrusion alarm controller: input register, control pass, result register.
// ============================================================================
// The controller takes one control-pass word per clock cycle while the output
// side does not stall and returns one result word for each, in order. The word
// is captured in an input register, the whole pass (clock tick, status report,
// sensor check, lamps and buzzer, command) runs as combinational logic against
// the controller state, and the result lands in an output register; that single
// state update per cycle sets the rate of one word per cycle. Configuration goes
// through an APB port and must be written only while the block is idle; the block
// itself does not enforce this. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module intrusion_alarm_controller_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [aic_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // Input words
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_tick,
    input  logic [5:0]                     i_day_sensors,
    input  logic [5:0]                     i_night_sensors,
    input  logic [2:0]                     i_kind,
    input  logic [1:0]                     i_mode_value,
    input  logic [31:0]                    i_pin_code,
    input  logic [3:0]                     i_access_digit,
    // Result words
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_lamps_on,
    output logic                           o_buzzer_on,
    output logic                           o_door_locked,
    output logic                           o_alarm_state,
    output logic [3:0]                     o_level_now,
    output logic [1:0]                     o_mode_now,
    output logic [1:0]                     o_pin_verdict,
    output logic                           o_report_due,
    output logic [5:0]                     o_day_tripped,
    output logic [5:0]                     o_night_tripped
);

    aic_pkg::t_cfg    w_cfg;
    aic_pkg::t_item   r_in;
    aic_pkg::t_result w_result, r_out;
    logic             r_in_valid, r_out_valid;
    logic             w_out_free, w_advance, w_in_accept;

    aic_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    aic_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Flow control: the held word runs its pass when the result register frees.
    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_advance   = r_in_valid && w_out_free;
    assign o_stall     = r_in_valid && !w_out_free;
    assign w_in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Input and result payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in.tick          <= i_tick;
            r_in.day_sensors   <= i_day_sensors;
            r_in.night_sensors <= i_night_sensors;
            r_in.kind          <= i_kind;
            r_in.mode_value    <= i_mode_value;
            r_in.pin_code      <= i_pin_code;
            r_in.access_digit  <= i_access_digit;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_lamps_on      = r_out.lamps_on;
    assign o_buzzer_on     = r_out.buzzer_on;
    assign o_door_locked   = r_out.door_locked;
    assign o_alarm_state   = r_out.alarm_state;
    assign o_level_now     = r_out.level_now;
    assign o_mode_now      = r_out.mode_now;
    assign o_pin_verdict   = r_out.pin_verdict;
    assign o_report_due    = r_out.report_due;
    assign o_day_tripped   = r_out.day_tripped;
    assign o_night_tripped = r_out.night_tripped;

    // Assertions on the pipeline and on result consistency.
    `ASSERT_SAME(a_stall_needs_word, i_clk, i_rst_n, !r_in_valid, !o_stall, "stall with empty input stage")
    `ASSERT_NEXT(a_pass_lands, i_clk, i_rst_n, w_advance, r_out_valid, "finished pass not held in result register")
    `ASSERT_SAME(a_buzz_lamps, i_clk, i_rst_n, r_out_valid && r_out.buzzer_on, r_out.lamps_on, "buzzer without lamps")
    `ASSERT_SAME(a_alarm_verdict, i_clk, i_rst_n, r_out_valid && (r_out.pin_verdict == aic_pkg::VERDICT_ALARM), r_out.alarm_state, "third wrong PIN without alarm")

endmodule

// File: rtl/core/aic_cfg_regs.sv
// ============================================================================
// aic_cfg_regs
// APB register file holding the delays, report interval, PIN and start mode.
// ============================================================================
`timescale 1ns / 1ps

module aic_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [aic_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output aic_pkg::t_cfg                    o_cfg
);

    logic [31:0] r_entry_delay;
    logic [31:0] r_buzzer_lim;
    logic [15:0] r_report_int;
    logic [31:0] r_correct_pin;
    logic [1:0]  r_start_mode;
    logic [2:0]  w_index;
    logic        w_write;

    assign pready  = 1'b1;
    assign w_index = paddr[aic_pkg::CFG_ADDR_W-1:2];
    assign w_write = psel & penable & pwrite;

    // Register writes in the access phase; writes past the map are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_delay <= aic_pkg::RST_ENTRY_DELAY;
            r_buzzer_lim  <= aic_pkg::RST_BUZZER_LIM;
            r_report_int  <= aic_pkg::RST_REPORT_INT;
            r_correct_pin <= aic_pkg::RST_CORRECT_PIN;
            r_start_mode  <= aic_pkg::RST_START_MODE;
        end else if (w_write) begin
            unique case (w_index)
                aic_pkg::REG_ENTRY_DELAY: r_entry_delay <= pwdata;
                aic_pkg::REG_BUZZER_LIM:  r_buzzer_lim  <= pwdata;
                aic_pkg::REG_REPORT_INT:  r_report_int  <= pwdata[15:0];
                aic_pkg::REG_CORRECT_PIN: r_correct_pin <= pwdata;
                aic_pkg::REG_START_MODE:  r_start_mode  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // Read back.
    always_comb begin
        unique case (w_index)
            aic_pkg::REG_ENTRY_DELAY: prdata = r_entry_delay;
            aic_pkg::REG_BUZZER_LIM:  prdata = r_buzzer_lim;
            aic_pkg::REG_REPORT_INT:  prdata = {16'd0, r_report_int};
            aic_pkg::REG_CORRECT_PIN: prdata = r_correct_pin;
            aic_pkg::REG_START_MODE:  prdata = {30'd0, r_start_mode};
            default:                  prdata = 32'd0;
        endcase
    end

    assign o_cfg.entry_delay_ms     = r_entry_delay;
    assign o_cfg.buzzer_limit_ms    = r_buzzer_lim;
    assign o_cfg.report_interval_ms = r_report_int;
    assign o_cfg.correct_pin        = r_correct_pin;

endmodule

// File: rtl/core/aic_core.sv
// ============================================================================
// aic_core
// Controller state and the combinational control pass over one input word.
// ============================================================================
`timescale 1ns / 1ps

module aic_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  aic_pkg::t_item    i_item,
    input  aic_pkg::t_cfg     i_cfg,
    output aic_pkg::t_result  o_result
);

    // Controller state.
    logic [31:0] r_clock, r_last_report, r_entry_start, r_exit_start, r_trig_start;
    logic [1:0]  r_mode;
    logic [3:0]  r_level;
    logic [7:0]  r_wrong;
    logic        r_alarm, r_alarm_was, r_entry_pend, r_entry_was, r_exit_pend, r_lock;

    logic [31:0] n_clock, n_last_report, n_entry_start, n_exit_start, n_trig_start;
    logic [1:0]  n_mode;
    logic [3:0]  n_level;
    logic [7:0]  n_wrong;
    logic        n_alarm, n_alarm_was, n_entry_pend, n_entry_was, n_exit_pend, n_lock;

    // Intermediate values of the pass.
    logic [5:0]  w_day, w_night, w_day_out, w_night_out;
    logic        w_report, w_entry_night, w_entry_expired, w_exit_expired;
    logic [31:0] w_entry_start_eff, w_trig_eff;
    logic        w_lamps, w_buzz, w_pin_ok;
    logic [1:0]  w_verdict;

    always_comb begin
        w_day   = i_item.day_sensors & aic_pkg::SENSOR_MASK;
        w_night = i_item.night_sensors & aic_pkg::SENSOR_MASK;

        // Millisecond clock and rate-limited status report.
        n_clock       = r_clock + 32'(i_item.tick);
        w_report      = n_clock > (r_last_report + {16'd0, i_cfg.report_interval_ms});
        n_last_report = w_report ? n_clock : r_last_report;

        // Entry and exit timers as seen in night mode.
        w_entry_night     = r_entry_pend | (|w_night);
        w_entry_start_eff = (!r_entry_was && w_entry_night) ? n_clock : r_entry_start;
        w_entry_expired   = n_clock > (w_entry_start_eff + i_cfg.entry_delay_ms);
        w_exit_expired    = n_clock > (r_exit_start + i_cfg.entry_delay_ms);

        n_alarm       = r_alarm;
        n_lock        = r_lock;
        n_entry_pend  = r_entry_pend;
        n_entry_was   = r_entry_was;
        n_entry_start = r_entry_start;
        n_exit_pend   = r_exit_pend;
        n_exit_start  = r_exit_start;
        w_day_out     = 6'd0;
        w_night_out   = 6'd0;

        // Sensor check for the mode in force at the start of the pass.
        unique case (r_mode)
            aic_pkg::MODE_DAY: begin
                n_lock    = 1'b0;
                w_day_out = w_day;
                if (|w_day) n_alarm = 1'b1;
            end
            aic_pkg::MODE_NIGHT: begin
                n_lock        = 1'b1;
                w_night_out   = w_night;
                n_entry_pend  = w_entry_night;
                n_entry_start = w_entry_start_eff;
                n_entry_was   = w_entry_night;
                if (w_entry_night && w_entry_expired) n_alarm = 1'b1;
                n_exit_pend   = r_exit_pend && !w_exit_expired;
                w_day_out     = w_day;
                if ((|w_day) && !n_exit_pend) n_alarm = 1'b1;
            end
            aic_pkg::MODE_IDLE: begin
                n_alarm = 1'b0;
            end
            default: ;
        endcase

        // Lamps and buzzer follow the alarm flag before the command.
        n_level      = r_level;
        n_trig_start = r_trig_start;
        w_trig_eff   = r_alarm_was ? r_trig_start : n_clock;
        w_lamps      = n_alarm;
        w_buzz       = n_alarm && (n_clock < (w_trig_eff + i_cfg.buzzer_limit_ms));
        n_alarm_was  = n_alarm;
        if (n_alarm) begin
            n_level      = aic_pkg::LEVEL_NONE;
            n_trig_start = w_trig_eff;
        end

        // Command.
        n_mode    = r_mode;
        n_wrong   = r_wrong;
        w_verdict = aic_pkg::VERDICT_NONE;
        w_pin_ok  = ((i_item.pin_code ^ i_cfg.correct_pin) & aic_pkg::PIN_MASK) == 32'd0;
        unique case (i_item.kind)
            aic_pkg::KIND_MODE: begin
                if (r_mode == aic_pkg::MODE_DAY && i_item.mode_value == aic_pkg::MODE_NIGHT)
                begin
                    n_exit_pend  = 1'b1;
                    n_exit_start = n_clock;
                    n_level      = aic_pkg::LEVEL_NONE;
                end
                n_mode = i_item.mode_value;
            end
            aic_pkg::KIND_FACE: begin
                n_level = aic_pkg::LEVEL_FACE;
            end
            aic_pkg::KIND_PIN: begin
                if (w_pin_ok) begin
                    n_level      = aic_pkg::LEVEL_PIN;
                    n_wrong      = 8'd0;
                    n_entry_pend = 1'b0;
                    n_alarm      = 1'b0;
                    w_verdict    = aic_pkg::VERDICT_OK;
                end else begin
                    if (r_wrong != aic_pkg::WRONG_MAX) n_wrong = r_wrong + 8'd1;
                    if (n_wrong == aic_pkg::WRONG_LIMIT) begin
                        n_alarm   = 1'b1;
                        w_verdict = aic_pkg::VERDICT_ALARM;
                    end else begin
                        w_verdict = aic_pkg::VERDICT_WRONG;
                    end
                end
            end
            aic_pkg::KIND_LEVEL: begin
                if (i_item.access_digit <= n_level) n_level = i_item.access_digit;
            end
            default: ;
        endcase

        o_result.lamps_on      = w_lamps;
        o_result.buzzer_on     = w_buzz;
        o_result.door_locked   = n_lock;
        o_result.alarm_state   = n_alarm;
        o_result.level_now     = n_level;
        o_result.mode_now      = n_mode;
        o_result.pin_verdict   = w_verdict;
        o_result.report_due    = w_report;
        o_result.day_tripped   = w_day_out;
        o_result.night_tripped = w_night_out;
    end

    // State update once per accepted pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock       <= 32'd0;
            r_last_report <= 32'd0;
            r_entry_start <= 32'd0;
            r_exit_start  <= 32'd0;
            r_trig_start  <= 32'd0;
            r_mode        <= aic_pkg::RST_START_MODE;
            r_level       <= aic_pkg::LEVEL_NONE;
            r_wrong       <= 8'd0;
            r_alarm       <= 1'b0;
            r_alarm_was   <= 1'b0;
            r_entry_pend  <= 1'b0;
            r_entry_was   <= 1'b0;
            r_exit_pend   <= 1'b0;
            r_lock        <= 1'b0;
        end else if (i_step) begin
            r_clock       <= n_clock;
            r_last_report <= n_last_report;
            r_entry_start <= n_entry_start;
            r_exit_start  <= n_exit_start;
            r_trig_start  <= n_trig_start;
            r_mode        <= n_mode;
            r_level       <= n_level;
            r_wrong       <= n_wrong;
            r_alarm       <= n_alarm;
            r_alarm_was   <= n_alarm_was;
            r_entry_pend  <= n_entry_pend;
            r_entry_was   <= n_entry_was;
            r_exit_pend   <= n_exit_pend;
            r_lock        <= n_lock;
        end
    end

endmodule

// File: test/aic_result_checker.sv
// ============================================================================
// aic_result_checker
// Watches the alarm controller's ports, predicts each result word and checks it.
// ============================================================================
// Every accepted input word runs through a local model of the control pass.
// That model keeps its own copy of the controller state and of the registers.
// It picks up register writes from the APB port. The predicted word is queued
// and compared field by field with the next accepted result word.
`timescale 1ns / 1ps

module aic_result_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // APB port, watched for register writes
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [aic_pkg::CFG_ADDR_W-1:0] i_paddr,
    input  logic [31:0]                   i_pwdata,
    input  logic                          i_pready,
    // Input channel
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  aic_pkg::t_item                i_in_word,
    // Result channel
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  aic_pkg::t_result              i_out_word,
    // Status toward the testbench top
    output int                            o_error_count,
    output int                            o_pending
);

    // Register copies.
    logic [31:0] cfg_entry_delay;
    logic [31:0] cfg_buzzer_limit;
    logic [15:0] cfg_report_interval;
    logic [31:0] cfg_pin;
    logic [1:0]  cfg_start_mode;

    // Controller state copies.
    logic [31:0] clock_now;
    logic [1:0]  mode_cur;
    logic [3:0]  level_cur;
    logic        alarm_on;
    logic        alarm_prev;
    logic        entry_armed;
    logic        entry_prev;
    logic        exit_armed;
    logic [31:0] entry_t0;
    logic [31:0] exit_t0;
    logic [31:0] trigger_t0;
    logic [31:0] last_report_t;
    logic [7:0]  wrong_count;
    logic        door_lock;

    // Predicted result words, oldest first.
    aic_pkg::t_result expected_results[$];
    aic_pkg::t_result predicted;
    aic_pkg::t_result oldest;
    int               result_index;

    initial begin
        o_error_count = 0;
        o_pending     = 0;
        result_index  = 0;
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_error_count = o_error_count + 1;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                                      result_index, name, got, want));
    endtask

    // One control pass: tick, report, sensor check, lamps and buzzer, command.
    task automatic run_control_pass(input aic_pkg::t_item w, output aic_pkg::t_result r);
        logic [5:0]  day;
        logic [5:0]  night;
        logic [31:0] bound;
        day   = w.day_sensors & aic_pkg::SENSOR_MASK;
        night = w.night_sensors & aic_pkg::SENSOR_MASK;
        r     = '0;

        clock_now = clock_now + 32'(w.tick);

        // Rate-limited status report; the bound wraps modulo 2^32.
        bound = last_report_t + 32'(cfg_report_interval);
        if (clock_now > bound) begin
            last_report_t = clock_now;
            r.report_due  = 1'b1;
        end

        // Sensor check for the current mode.
        unique case (mode_cur)
            aic_pkg::MODE_DAY: begin
                door_lock     = 1'b0;
                r.day_tripped = day;
                if (day != 6'd0) alarm_on = 1'b1;
            end
            aic_pkg::MODE_NIGHT: begin
                door_lock       = 1'b1;
                r.night_tripped = night;
                if (night != 6'd0) entry_armed = 1'b1;
                if (!entry_prev && entry_armed) entry_t0 = clock_now;
                entry_prev = entry_armed;
                bound = entry_t0 + cfg_entry_delay;
                if (entry_armed && clock_now > bound) alarm_on = 1'b1;
                bound = exit_t0 + cfg_entry_delay;
                if (exit_armed && clock_now > bound) exit_armed = 1'b0;
                r.day_tripped = day;
                if (day != 6'd0 && !exit_armed) alarm_on = 1'b1;
            end
            aic_pkg::MODE_IDLE: begin
                alarm_on = 1'b0;
            end
            default: ;
        endcase

        // Lamps and buzzer follow the alarm flag before the command.
        if (alarm_on) begin
            level_cur  = aic_pkg::LEVEL_NONE;
            r.lamps_on = 1'b1;
            if (!alarm_prev) trigger_t0 = clock_now;
            bound       = trigger_t0 + cfg_buzzer_limit;
            r.buzzer_on = (clock_now < bound);
            alarm_prev  = 1'b1;
        end else begin
            alarm_prev = 1'b0;
        end

        // At most one command; unknown kinds fall through.
        unique case (w.kind)
            aic_pkg::KIND_MODE: begin
                if (mode_cur == aic_pkg::MODE_DAY && w.mode_value == aic_pkg::MODE_NIGHT)
                begin
                    exit_armed = 1'b1;
                    exit_t0    = clock_now;
                    level_cur  = aic_pkg::LEVEL_NONE;
                end
                mode_cur = w.mode_value;
            end
            aic_pkg::KIND_FACE: begin
                level_cur = aic_pkg::LEVEL_FACE;
            end
            aic_pkg::KIND_PIN: begin
                if (((w.pin_code ^ cfg_pin) & aic_pkg::PIN_MASK) == 32'd0) begin
                    level_cur     = aic_pkg::LEVEL_PIN;
                    wrong_count   = 8'd0;
                    entry_armed   = 1'b0;
                    alarm_on      = 1'b0;
                    r.pin_verdict = aic_pkg::VERDICT_OK;
                end else begin
                    if (wrong_count < aic_pkg::WRONG_MAX) wrong_count = wrong_count + 8'd1;
                    if (wrong_count == aic_pkg::WRONG_LIMIT) begin
                        alarm_on      = 1'b1;
                        r.pin_verdict = aic_pkg::VERDICT_ALARM;
                    end else begin
                        r.pin_verdict = aic_pkg::VERDICT_WRONG;
                    end
                end
            end
            aic_pkg::KIND_LEVEL: begin
                if (w.access_digit <= level_cur) level_cur = w.access_digit;
            end
            default: ;
        endcase

        r.door_locked = door_lock;
        r.alarm_state = alarm_on;
        r.level_now   = level_cur;
        r.mode_now    = mode_cur;
    endtask

    // Sample every port at the rising edge, before the block's outputs move.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_entry_delay     = aic_pkg::RST_ENTRY_DELAY;
            cfg_buzzer_limit    = aic_pkg::RST_BUZZER_LIM;
            cfg_report_interval = aic_pkg::RST_REPORT_INT;
            cfg_pin             = aic_pkg::RST_CORRECT_PIN;
            cfg_start_mode      = aic_pkg::RST_START_MODE;
            clock_now     = '0;
            mode_cur      = cfg_start_mode;
            level_cur     = aic_pkg::LEVEL_NONE;
            alarm_on      = 1'b0;
            alarm_prev    = 1'b0;
            entry_armed   = 1'b0;
            entry_prev    = 1'b0;
            exit_armed    = 1'b0;
            entry_t0      = '0;
            exit_t0       = '0;
            trigger_t0    = '0;
            last_report_t = '0;
            wrong_count   = 8'd0;
            door_lock     = 1'b0;
            expected_results.delete();
        end else begin
            // Register writes.
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[aic_pkg::CFG_ADDR_W-1:2])
                    aic_pkg::REG_ENTRY_DELAY: cfg_entry_delay     = i_pwdata;
                    aic_pkg::REG_BUZZER_LIM:  cfg_buzzer_limit    = i_pwdata;
                    aic_pkg::REG_REPORT_INT:  cfg_report_interval = i_pwdata[15:0];
                    aic_pkg::REG_CORRECT_PIN: cfg_pin             = i_pwdata;
                    aic_pkg::REG_START_MODE:  cfg_start_mode      = i_pwdata[1:0];
                    default: ;
                endcase
            end

            // Compare an accepted result word with the oldest prediction.
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result word arrived with no expectation waiting");
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("lamps_on",      32'(i_out_word.lamps_on),
                                32'(oldest.lamps_on));
                    check_field("buzzer_on",     32'(i_out_word.buzzer_on),
                                32'(oldest.buzzer_on));
                    check_field("door_locked",   32'(i_out_word.door_locked),
                                32'(oldest.door_locked));
                    check_field("alarm_state",   32'(i_out_word.alarm_state),
                                32'(oldest.alarm_state));
                    check_field("level_now",     32'(i_out_word.level_now),
                                32'(oldest.level_now));
                    check_field("mode_now",      32'(i_out_word.mode_now),
                                32'(oldest.mode_now));
                    check_field("pin_verdict",   32'(i_out_word.pin_verdict),
                                32'(oldest.pin_verdict));
                    check_field("report_due",    32'(i_out_word.report_due),
                                32'(oldest.report_due));
                    check_field("day_tripped",   32'(i_out_word.day_tripped),
                                32'(oldest.day_tripped));
                    check_field("night_tripped", 32'(i_out_word.night_tripped),
                                32'(oldest.night_tripped));
                end
                result_index = result_index + 1;
            end

            // Predict the result of an accepted input word.
            if (i_in_valid && !i_in_stall) begin
                run_control_pass(i_in_word, predicted);
                expected_results.push_back(predicted);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// File: test/tb_top.sv
// ============================================================================
// tb_top
// Testbench top for the intrusion alarm controller.
// ============================================================================
// Resets the block once, then runs a short directed sequence and several
// random phases, each under its own register setting, with bursts of idle
// cycles on the input side and stalls on the result side. A separate checker
// predicts and compares every result word; this module only drives stimulus,
// watches for a hang and prints the verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 375;

    logic                           i_clk;
    logic                           i_rst_n = 1'b0;

    // APB port
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [aic_pkg::CFG_ADDR_W-1:0] paddr   = '0;
    logic [31:0]                    pwdata  = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    // Input channel
    logic                           i_valid    = 1'b0;
    logic                           o_stall;
    aic_pkg::t_item                 drive_word = '0;

    // Result channel
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    logic                           o_lamps_on;
    logic                           o_buzzer_on;
    logic                           o_door_locked;
    logic                           o_alarm_state;
    logic [3:0]                     o_level_now;
    logic [1:0]                     o_mode_now;
    logic [1:0]                     o_pin_verdict;
    logic                           o_report_due;
    logic [5:0]                     o_day_tripped;
    logic [5:0]                     o_night_tripped;
    aic_pkg::t_result               dut_result;

    int                             error_count;
    int                             pending_count;
    int                             idle_cycles = 0;
    bit                             quiet_tail  = 1'b0;
    logic [31:0]                    cur_pin     = aic_pkg::RST_CORRECT_PIN;

    assign dut_result = {o_lamps_on, o_buzzer_on, o_door_locked, o_alarm_state,
                         o_level_now, o_mode_now, o_pin_verdict, o_report_due,
                         o_day_tripped, o_night_tripped};

    intrusion_alarm_controller_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_tick          (drive_word.tick),
        .i_day_sensors   (drive_word.day_sensors),
        .i_night_sensors (drive_word.night_sensors),
        .i_kind          (drive_word.kind),
        .i_mode_value    (drive_word.mode_value),
        .i_pin_code      (drive_word.pin_code),
        .i_access_digit  (drive_word.access_digit),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_lamps_on      (o_lamps_on),
        .o_buzzer_on     (o_buzzer_on),
        .o_door_locked   (o_door_locked),
        .o_alarm_state   (o_alarm_state),
        .o_level_now     (o_level_now),
        .o_mode_now      (o_mode_now),
        .o_pin_verdict   (o_pin_verdict),
        .o_report_due    (o_report_due),
        .o_day_tripped   (o_day_tripped),
        .o_night_tripped (o_night_tripped)
    );

    aic_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_in_word     (drive_word),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_out_word    (dut_result),
        .o_error_count (error_count),
        .o_pending     (pending_count)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Count cycles in which neither channel nor the APB port moves a word.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Watchdog: a hang ends the run.
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("*** FAILED ***");
        $finish;
    end

    // Result-side stalls in random bursts, none in the tail of the run.
    initial begin
        forever begin
            repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 150 : 40))
                @(posedge i_clk);
            if (!quiet_tail) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Two-phase APB write; the register takes the value in the access cycle.
    task automatic apb_write(input logic [2:0] reg_index, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Let the block drain, then load a full register setting.
    task automatic program_registers(input logic [31:0] entry_delay,
                                     input logic [31:0] buzzer_limit,
                                     input logic [31:0] report_interval,
                                     input logic [31:0] pin,
                                     input logic [31:0] start_mode);
        i_valid <= 1'b0;
        while (pending_count != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        apb_write(aic_pkg::REG_ENTRY_DELAY, entry_delay);
        apb_write(aic_pkg::REG_BUZZER_LIM,  buzzer_limit);
        apb_write(aic_pkg::REG_REPORT_INT,  report_interval);
        apb_write(aic_pkg::REG_CORRECT_PIN, pin);
        apb_write(aic_pkg::REG_START_MODE,  start_mode);
        cur_pin = pin;
        @(posedge i_clk);
    endtask

    // Present one word and hold it until the block takes it.
    task automatic push_word(input aic_pkg::t_item w);
        i_valid    <= 1'b1;
        drive_word <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic aic_pkg::t_item make_word(input logic tick, input logic [5:0] day,
                                                 input logic [5:0] night,
                                                 input logic [2:0] kind,
                                                 input logic [1:0] mval,
                                                 input logic [31:0] pin,
                                                 input logic [3:0] digit);
        aic_pkg::t_item w;
        w.tick          = tick;
        w.day_sensors   = day;
        w.night_sensors = night;
        w.kind          = kind;
        w.mode_value    = mval;
        w.pin_code      = pin;
        w.access_digit  = digit;
        return w;
    endfunction

    // Random control pass: mostly quiet passes and legal commands, some noise.
    function automatic aic_pkg::t_item make_random_word();
        aic_pkg::t_item w;
        int             sel;
        int             msel;
        w.tick          = ($urandom_range(0, 99) < 60);
        w.day_sensors   = ($urandom_range(0, 99) < 12) ? 6'($urandom) : 6'd0;
        w.night_sensors = ($urandom_range(0, 99) < 15) ? 6'($urandom) : 6'd0;
        w.mode_value    = 2'($urandom);
        w.pin_code      = $urandom;
        w.access_digit  = 4'($urandom_range(0, 9));
        sel             = $urandom_range(0, 99);
        if (sel < 45) begin
            w.kind = aic_pkg::KIND_NONE;
        end else if (sel < 57) begin
            w.kind = aic_pkg::KIND_MODE;
            msel   = $urandom_range(0, 9);
            w.mode_value = (msel < 4) ? aic_pkg::MODE_NIGHT :
                           (msel < 7) ? aic_pkg::MODE_DAY :
                           (msel < 9) ? aic_pkg::MODE_IDLE : aic_pkg::MODE_OTHER;
        end else if (sel < 64) begin
            w.kind = aic_pkg::KIND_FACE;
        end else if (sel < 82) begin
            w.kind = aic_pkg::KIND_PIN;
            msel   = $urandom_range(0, 3);
            if (msel < 2)
                w.pin_code = cur_pin;
            else if (msel == 2)
                w.pin_code = cur_pin ^ (32'd1 << $urandom_range(0, 31));
        end else if (sel < 95) begin
            w.kind = aic_pkg::KIND_LEVEL;
        end else begin
            w.kind = 3'($urandom_range(5, 7));
        end
        return w;
    endfunction

    // A phase of random words with input-side gaps in changing densities.
    task automatic send_random_words(input int count);
        int gap_pct;
        gap_pct = 0;
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0)
                gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
            if (!quiet_tail && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            push_word(make_random_word());
        end
    endtask

    // Main sequence.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Short timers so the delays run out within a few words.
        program_registers(32'd2, 32'd5, 32'd2, aic_pkg::RST_CORRECT_PIN,
                          32'(aic_pkg::MODE_NIGHT));

        // Day trip, login and level drops, idle clearing the alarm.
        push_word(make_word(1'b1, 6'd0,  6'd0,  aic_pkg::KIND_NONE,  aic_pkg::MODE_DAY,
                            32'd0, 4'd0));
        push_word(make_word(1'b1, 6'h3F, 6'h3F, aic_pkg::KIND_NONE,  aic_pkg::MODE_DAY,
                            32'd0, 4'd0));
        push_word(make_word(1'b1, 6'd0,  6'd0,  aic_pkg::KIND_FACE,  aic_pkg::MODE_DAY,
                            32'd0, 4'd0));
        push_word(make_word(1'b0, 6'd0,  6'd0,  aic_pkg::KIND_LEVEL, aic_pkg::MODE_DAY,
                            32'd0, 4'd9));
        push_word(make_word(1'b1, 6'd0,  6'd0,  aic_pkg::KIND_MODE,  aic_pkg::MODE_IDLE,
                            32'd0, 4'd0));
        push_word(make_word(1'b1, 6'd0,  6'd0,  aic_pkg::KIND_LEVEL, aic_pkg::MODE_DAY,
                            32'd0, 4'd1));
        push_word(make_word(1'b0, 6'd0,  6'd0,  aic_pkg::KIND_LEVEL, aic_pkg::MODE_DAY,
                            32'd0, 4'd0));
        push_word(make_word(1'b1, 6'd0,  6'd0,  aic_pkg::KIND_MODE,  aic_pkg::MODE_DAY,
                            32'd0, 4'd8));
        // Day to night starts the exit delay; a day sensor inside it is only reported.
        push_word(make_word(1'b1, 6'd0,  6'd0,  aic_pkg::KIND_MODE,  aic_pkg::MODE_NIGHT,
                            32'd0, 4'd0));
        push_word(make_word(1'b1, 6'h21, 6'd0,  aic_pkg::KIND_NONE,  aic_pkg::MODE_DAY,
                            32'd0, 4'd0));
        push_word(make_word(1'b1, 6'd0,  6'd0,  aic_pkg::KIND_NONE,  aic_pkg::MODE_DAY,
                            32'd0, 4'd0));
        push_word(make_word(1'b1, 6'd0,  6'd0,  aic_pkg::KIND_NONE,  aic_pkg::MODE_DAY,
                            32'd0, 4'd0));
        // A night sensor arms the entry delay, which then runs out.
        push_word(make_word(1'b1, 6'd0,  6'h3F, aic_pkg::KIND_NONE,  aic_pkg::MODE_DAY,
                            32'd0, 4'd0));
        push_word(make_word(1'b1, 6'd0,  6'd0,  aic_pkg::KIND_NONE,  aic_pkg::MODE_DAY,
                            32'd0, 4'd0));
        push_word(make_word(1'b1, 6'd0,  6'd0,  aic_pkg::KIND_NONE,  aic_pkg::MODE_DAY,
                            32'd0, 4'd0));
        push_word(make_word(1'b1, 6'd0,  6'd0,  aic_pkg::KIND_NONE,  aic_pkg::MODE_DAY,
                            32'd0, 4'd0));
        // Wrong PINs: the third raises the alarm, the fourth does not.
        push_word(make_word(1'b1, 6'd0,  6'd0,  aic_pkg::KIND_PIN,   aic_pkg::MODE_DAY,
                            32'd0, 4'd0));
        push_word(make_word(1'b0, 6'd0,  6'd0,  aic_pkg::KIND_PIN,   aic_pkg::MODE_DAY,
                            32'hFFFF_FFFF, 4'd0));
        push_word(make_word(1'b1, 6'd0,  6'd0,  aic_pkg::KIND_PIN,   aic_pkg::MODE_DAY,
                            aic_pkg::RST_CORRECT_PIN ^ 32'd1, 4'd0));
        push_word(make_word(1'b1, 6'd0,  6'd0,  aic_pkg::KIND_PIN,   aic_pkg::MODE_DAY,
                            aic_pkg::RST_CORRECT_PIN ^ 32'h8000_0000, 4'd0));
        push_word(make_word(1'b1, 6'd0,  6'd0,  aic_pkg::KIND_PIN,   aic_pkg::MODE_DAY,
                            aic_pkg::RST_CORRECT_PIN, 4'd0));
        // The other mode checks nothing; unknown commands do nothing.
        push_word(make_word(1'b1, 6'h3F, 6'h3F, aic_pkg::KIND_MODE,  aic_pkg::MODE_OTHER,
                            32'd0, 4'd0));
        push_word(make_word(1'b1, 6'h3F, 6'h3F, 3'd5,                aic_pkg::MODE_NIGHT,
                            32'd0, 4'd9));
        push_word(make_word(1'b0, 6'h15, 6'h2A, 3'd6,                aic_pkg::MODE_IDLE,
                            aic_pkg::RST_CORRECT_PIN, 4'd0));
        push_word(make_word(1'b1, 6'h2A, 6'h15, 3'd7,                aic_pkg::MODE_DAY,
                            32'hFFFF_FFFF, 4'd2));

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: program_registers(32'd0, 32'd0, 32'd0, 32'd0, 32'(aic_pkg::MODE_OTHER));
                1: program_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF,
                                     32'hFFFF_FFFF, 32'(aic_pkg::MODE_NIGHT));
                2: program_registers(32'($urandom_range(1, 30)), 32'($urandom_range(1, 40)),
                                     {16'($urandom), 16'($urandom_range(0, 15))},
                                     $urandom, $urandom);
                3: program_registers(aic_pkg::RST_ENTRY_DELAY, aic_pkg::RST_BUZZER_LIM,
                                     32'(aic_pkg::RST_REPORT_INT),
                                     aic_pkg::RST_CORRECT_PIN, 32'(aic_pkg::MODE_IDLE));
                default: begin
                    quiet_tail = 1'b1;
                    program_registers(32'($urandom_range(1, 12)), 32'($urandom_range(1, 20)),
                                      32'($urandom_range(0, 6)), $urandom,
                                      32'(aic_pkg::MODE_DAY));
                end
            endcase
            send_random_words(PHASE_WORDS);
        end
        i_valid <= 1'b0;

        // Drain, then allow for the pipeline before the verdict.
        while (pending_count != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/aic_pkg.sv
rtl/core/aic_cfg_regs.sv
rtl/core/aic_core.sv
rtl/core/intrusion_alarm_controller_top.sv
test/aic_result_checker.sv
test/tb_top.sv
